[hdl/iida_pkg.sv]
// Shared types and constants for the indexed insert/delete array.
`timescale 1ns / 1ps
package iida_pkg;
	localparam int CAPACITY = 128;
	localparam int DATA_W = 32;
	localparam int POS_W = 8;
	localparam int CNT_OUT_W = 8;
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
	localparam int GROUP = 8;
	localparam int NGROUP = (CAPACITY + GROUP - 1) / GROUP;

	typedef enum logic [1:0] {
		REQ_READ = 2'd0,
		REQ_INSERT = 2'd1,
		REQ_REMOVE = 2'd2,
		REQ_CLEAR = 2'd3
	} req_type_t;

	typedef enum logic [1:0] {
		ST_OK = 2'd0,
		ST_BAD_INDEX = 2'd1,
		ST_FULL = 2'd2
	} status_t;

	typedef struct packed {
		logic ins;
		logic rem;
		logic rd;
		logic [CMP_W-1:0] pos;
		logic signed [DATA_W-1:0] value;
	} cell_ctrl_t;

	typedef struct packed {
		status_t status;
		logic [CNT_OUT_W-1:0] count;
	} rsp_ctl_t;
endpackage

[hdl/iida_req_if.sv]
// Request channel: valid/ready handshake with the request fields.
`timescale 1ns / 1ps
interface iida_req_if;
	logic valid;
	logic ready;
	logic [1:0] req_type;
	logic [7:0] position;
	logic signed [31:0] new_value;

	modport source (output valid, output req_type, output position, output new_value,
		input ready);
	modport sink (input valid, input req_type, input position, input new_value,
		output ready);
endinterface

[hdl/iida_rsp_if.sv]
// Response channel: valid/ready handshake with the result fields.
`timescale 1ns / 1ps
interface iida_rsp_if;
	logic valid;
	logic ready;
	logic [1:0] status;
	logic signed [31:0] read_value;
	logic [7:0] count;

	modport source (output valid, output status, output read_value, output count,
		input ready);
	modport sink (input valid, input status, input read_value, input count,
		output ready);
endinterface

[hdl/indexed_insert_delete_array.sv]
// Top level of the indexed insert/delete array: cell row, read tree and control.
`timescale 1ns / 1ps
// Ordered list of up to CAPACITY signed 32-bit elements kept in a row of cells. Each request
// (read, insert, remove, clear) gives one response carrying status, the element for a good read
// and the element count after the request. One request is in flight at a time: a request is
// taken in one cycle, in which inserts and removes shift the cells from the position upward at
// once, and the selected element passes the two-level registered OR tree and then the output
// register; the next request is taken as soon as the response reaches the output register, so
// one request is through before the next is taken. Element storage is not cleared at reset;
// only the count is, and reads are limited to indices below the count.
module indexed_insert_delete_array
	import iida_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	iida_req_if.sink req,
	iida_rsp_if.source rsp
);
	logic acc;
	logic v_s1, v_s2, out_valid_q;
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] cnt_next;
	logic [CMP_W-1:0] pos_ext, cnt_ext;
	logic ins_ok, rem_ok, rd_ok;
	status_t status_c;
	cell_ctrl_t ctrl;
	rsp_ctl_t ctl_c, ctl_s1, ctl_s2, ctl_q;
	logic [DATA_W-1:0] rd_s2, rd_q;
	logic advance_out;
	logic signed [DATA_W-1:0] cell_val [CAPACITY];
	logic [DATA_W-1:0] taps [CAPACITY];

	assign req.ready = !v_s1 && !v_s2;
	assign acc = req.valid && req.ready;
	assign pos_ext = CMP_W'(req.position);
	assign cnt_ext = CMP_W'(cnt_q);

	always_comb begin
		status_c = ST_OK;
		ins_ok = 1'b0;
		rem_ok = 1'b0;
		rd_ok = 1'b0;
		cnt_next = cnt_q;
		unique case (req_type_t'(req.req_type))
			REQ_READ: begin
				if (pos_ext < cnt_ext) rd_ok = 1'b1;
				else status_c = ST_BAD_INDEX;
			end
			REQ_INSERT: begin
				if (pos_ext > cnt_ext) begin
					status_c = ST_BAD_INDEX;
				end else if (cnt_ext == CMP_W'(CAPACITY)) begin
					status_c = ST_FULL;
				end else begin
					ins_ok = 1'b1;
					cnt_next = cnt_q + 1'b1;
				end
			end
			REQ_REMOVE: begin
				if (pos_ext < cnt_ext) begin
					rem_ok = 1'b1;
					cnt_next = cnt_q - 1'b1;
				end else begin
					status_c = ST_BAD_INDEX;
				end
			end
			REQ_CLEAR: cnt_next = '0;
			default: status_c = ST_OK;
		endcase
	end

	assign ctrl.ins = acc && ins_ok;
	assign ctrl.rem = acc && rem_ok;
	assign ctrl.rd = acc && rd_ok;
	assign ctrl.pos = pos_ext;
	assign ctrl.value = req.new_value;

	assign ctl_c.status = status_c;
	assign ctl_c.count = CNT_OUT_W'(cnt_next);

	genvar i;
	generate
		for (i = 0; i < CAPACITY; i++) begin : g_cell
			logic signed [DATA_W-1:0] left_v, right_v, tap_v;
			if (i == 0) begin : g_first
				assign left_v = '0;
			end else begin : g_left
				assign left_v = cell_val[i-1];
			end
			if (i == CAPACITY - 1) begin : g_last
				assign right_v = '0;
			end else begin : g_right
				assign right_v = cell_val[i+1];
			end
			iida_cell u_cell (
				.clk(clk),
				.idx(CMP_W'(i)),
				.ctrl(ctrl),
				.left_value(left_v),
				.right_value(right_v),
				.value(cell_val[i]),
				.read_tap(tap_v)
			);
			assign taps[i] = tap_v;
		end
	endgenerate

	iida_read_tree u_tree (
		.clk(clk),
		.load_s1(acc),
		.load_s2(v_s1),
		.taps(taps),
		.result_s2(rd_s2)
	);

	assign advance_out = v_s2 && (!out_valid_q || rsp.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (acc) cnt_q <= cnt_next;
			v_s1 <= acc;
			if (v_s1) begin
				v_s2 <= 1'b1;
			end else if (advance_out) begin
				v_s2 <= 1'b0;
			end
			if (advance_out) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) ctl_s1 <= ctl_c;
		if (v_s1) ctl_s2 <= ctl_s1;
		if (advance_out) begin
			ctl_q <= ctl_s2;
			rd_q <= rd_s2;
		end
	end

	assign rsp.valid = out_valid_q;
	assign rsp.status = ctl_q.status;
	assign rsp.read_value = rd_q;
	assign rsp.count = ctl_q.count;

	a_count_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		CMP_W'(cnt_q) <= CMP_W'(CAPACITY))
		else $error("element count above capacity");

	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && req.req_type == REQ_CLEAR) |=> cnt_q == '0)
		else $error("clear did not empty the array");

	a_insert_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && ins_ok) |=> cnt_q == $past(cnt_q) + 1'b1)
		else $error("insert did not grow the count");

	a_fail_no_data: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.status != ST_OK) |-> rsp.read_value == '0)
		else $error("failed request returned data");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.status == ST_FULL) |-> rsp.count == CNT_OUT_W'(CAPACITY))
		else $error("full status with count below capacity");
endmodule

[hdl/iida_cell.sv]
// One storage cell of the array: holds one element, shifts to/from its neighbors.
`timescale 1ns / 1ps
module iida_cell
	import iida_pkg::*;
(
	input  logic clk,
	input  logic [CMP_W-1:0] idx,
	input  cell_ctrl_t ctrl,
	input  logic signed [DATA_W-1:0] left_value,
	input  logic signed [DATA_W-1:0] right_value,
	output logic signed [DATA_W-1:0] value,
	output logic signed [DATA_W-1:0] read_tap
);
	logic signed [DATA_W-1:0] value_q;
	logic at_pos;
	logic above_pos;

	assign at_pos = (idx == ctrl.pos);
	assign above_pos = (idx > ctrl.pos);

	always_ff @(posedge clk) begin
		if (ctrl.ins) begin
			if (above_pos) begin
				value_q <= left_value;
			end else if (at_pos) begin
				value_q <= ctrl.value;
			end
		end else if (ctrl.rem) begin
			if (above_pos || at_pos) begin
				value_q <= right_value;
			end
		end
	end

	assign value = value_q;
	assign read_tap = (ctrl.rd && at_pos) ? value_q : '0;
endmodule

[hdl/iida_read_tree.sv]
// Two-level registered OR tree that gathers the one selected cell value.
`timescale 1ns / 1ps
module iida_read_tree
	import iida_pkg::*;
(
	input  logic clk,
	input  logic load_s1,
	input  logic load_s2,
	input  logic [DATA_W-1:0] taps [CAPACITY],
	output logic [DATA_W-1:0] result_s2
);
	logic [DATA_W-1:0] padded [NGROUP*GROUP];
	logic [DATA_W-1:0] group_c [NGROUP];
	logic [DATA_W-1:0] group_s1 [NGROUP];
	logic [DATA_W-1:0] all_c;

	always_comb begin
		for (int i = 0; i < NGROUP * GROUP; i++) begin
			padded[i] = '0;
		end
		for (int i = 0; i < CAPACITY; i++) begin
			padded[i] = taps[i];
		end
		for (int g = 0; g < NGROUP; g++) begin
			group_c[g] = '0;
			for (int k = 0; k < GROUP; k++) begin
				group_c[g] = group_c[g] | padded[g*GROUP + k];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			group_s1 <= group_c;
		end
	end

	always_comb begin
		all_c = '0;
		for (int g = 0; g < NGROUP; g++) begin
			all_c = all_c | group_s1[g];
		end
	end

	always_ff @(posedge clk) begin
		if (load_s2) begin
			result_s2 <= all_c;
		end
	end
endmodule

[dv/tb.sv]
// Self-checking testbench for the indexed insert/delete array with random traffic and stalls.
`timescale 1ns / 1ps
module tb;
	import iida_pkg::*;

	localparam int NDIR = 25;
	localparam int HOLD_CYCLES = 300;
	localparam int QUIET_LIMIT = 3000;
	localparam int DRAIN_CYCLES = 10;
	localparam int PRINT_CAP = 50;

	typedef enum {GROW, SHRINK, CHURN} mix_t;

	typedef struct packed {
		status_t st;
		logic signed [31:0] rd;
		logic [7:0] cnt;
	} result_t;

	typedef struct packed {
		req_type_t kind;
		logic [7:0] pos;
		logic signed [31:0] val;
		logic typed_in;
		result_t want;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	iida_req_if req_ch();
	iida_rsp_if rsp_ch();

	indexed_insert_delete_array dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch)
	);

	logic signed [31:0] shadow_elems [CAPACITY];
	int shadow_len = 0;
	result_t owed_results [$];
	result_t head;
	int errors = 0;
	bit calm = 1'b0;
	int hold_requests = 0;
	int holds_done = 0;
	int hold_left = 0;
	int quiet_cycles = 0;

	// typed_in rows carry their answer; the rest take the shadow copy's answer
	dir_row_t directed_rows [NDIR] = '{
		'{REQ_READ, 8'd0, 32'sd0, 1'b1, '{ST_BAD_INDEX, 32'sd0, 8'd0}},
		'{REQ_REMOVE, 8'd0, 32'sd0, 1'b1, '{ST_BAD_INDEX, 32'sd0, 8'd0}},
		'{REQ_INSERT, 8'd1, 32'sd5, 1'b1, '{ST_BAD_INDEX, 32'sd0, 8'd0}},
		'{REQ_CLEAR, 8'd0, 32'sd0, 1'b1, '{ST_OK, 32'sd0, 8'd0}},
		'{REQ_INSERT, 8'd0, 32'sh7fffffff, 1'b1, '{ST_OK, 32'sd0, 8'd1}},
		'{REQ_INSERT, 8'd0, 32'sh80000000, 1'b1, '{ST_OK, 32'sd0, 8'd2}},
		'{REQ_INSERT, 8'd2, -32'sd1, 1'b1, '{ST_OK, 32'sd0, 8'd3}},
		'{REQ_INSERT, 8'd1, 32'sh12345678, 1'b0, '{ST_OK, 32'sd0, 8'd0}},
		'{REQ_READ, 8'd0, 32'sd0, 1'b1, '{ST_OK, 32'sh80000000, 8'd4}},
		'{REQ_READ, 8'd1, 32'sd0, 1'b0, '{ST_OK, 32'sd0, 8'd0}},
		'{REQ_READ, 8'd3, 32'sd0, 1'b1, '{ST_OK, -32'sd1, 8'd4}},
		'{REQ_READ, 8'd4, 32'sd0, 1'b1, '{ST_BAD_INDEX, 32'sd0, 8'd4}},
		'{REQ_READ, 8'd255, 32'sd0, 1'b1, '{ST_BAD_INDEX, 32'sd0, 8'd4}},
		'{REQ_INSERT, 8'd5, 32'sd7, 1'b1, '{ST_BAD_INDEX, 32'sd0, 8'd4}},
		'{REQ_INSERT, 8'd255, -32'sd1, 1'b1, '{ST_BAD_INDEX, 32'sd0, 8'd4}},
		'{REQ_INSERT, 8'd4, 32'sh55aa55aa, 1'b0, '{ST_OK, 32'sd0, 8'd0}},
		'{REQ_REMOVE, 8'd0, 32'sd0, 1'b0, '{ST_OK, 32'sd0, 8'd0}},
		'{REQ_REMOVE, 8'd4, 32'sd0, 1'b1, '{ST_BAD_INDEX, 32'sd0, 8'd4}},
		'{REQ_REMOVE, 8'd3, 32'sd0, 1'b0, '{ST_OK, 32'sd0, 8'd0}},
		'{REQ_READ, 8'd2, 32'sd0, 1'b0, '{ST_OK, 32'sd0, 8'd0}},
		'{REQ_REMOVE, 8'd255, 32'sd0, 1'b1, '{ST_BAD_INDEX, 32'sd0, 8'd3}},
		'{REQ_CLEAR, 8'd255, -32'sd1, 1'b1, '{ST_OK, 32'sd0, 8'd0}},
		'{REQ_READ, 8'd0, 32'sd0, 1'b1, '{ST_BAD_INDEX, 32'sd0, 8'd0}},
		'{REQ_INSERT, 8'd0, 32'sd0, 1'b1, '{ST_OK, 32'sd0, 8'd1}},
		'{REQ_READ, 8'd0, 32'sd0, 1'b1, '{ST_OK, 32'sd0, 8'd1}}
	};

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic result_t apply_request(req_type_t kind, logic [7:0] pos,
			logic signed [31:0] val);
		result_t r;
		int p;
		int i;
		r = '{ST_OK, 32'sd0, 8'd0};
		p = int'(pos);
		case (kind)
		REQ_READ: begin
			if (p < shadow_len)
				r.rd = shadow_elems[p];
			else
				r.st = ST_BAD_INDEX;
		end
		REQ_INSERT: begin
			if (p > shadow_len) begin
				r.st = ST_BAD_INDEX;
			end else if (shadow_len >= CAPACITY) begin
				r.st = ST_FULL;
			end else begin
				for (i = shadow_len; i > p; i--)
					shadow_elems[i] = shadow_elems[i - 1];
				shadow_elems[p] = val;
				shadow_len++;
			end
		end
		REQ_REMOVE: begin
			if (p < shadow_len) begin
				for (i = p; i + 1 < shadow_len; i++)
					shadow_elems[i] = shadow_elems[i + 1];
				shadow_len--;
			end else begin
				r.st = ST_BAD_INDEX;
			end
		end
		default: shadow_len = 0;
		endcase
		r.cnt = shadow_len[7:0];
		return r;
	endfunction

	function automatic logic signed [31:0] pick_value();
		case ($urandom_range(9))
		0: return 32'sd0;
		1: return -32'sd1;
		2: return 32'sh7fffffff;
		3: return 32'sh80000000;
		default: return $urandom;
		endcase
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		if (errors < PRINT_CAP)
			$display("%0t ns: %s got %h want %h", $time, what, got, want);
		errors++;
	endtask

	task automatic send_item(req_type_t kind, logic [7:0] pos, logic signed [31:0] val,
			bit typed_in, result_t want);
		result_t got;
		req_ch.valid <= 1'b1;
		req_ch.req_type <= kind;
		req_ch.position <= pos;
		req_ch.new_value <= val;
		@(posedge clk);
		while (req_ch.ready !== 1'b1)
			@(posedge clk);
		got = apply_request(kind, pos, val);
		owed_results.push_back(typed_in ? want : got);
		if (!calm && $urandom_range(99) < 9) begin
			req_ch.valid <= 1'b0;
			repeat ($urandom_range(4, 1)) @(posedge clk);
		end
	endtask

	task automatic send_random(mix_t mix);
		int roll;
		bit bad;
		req_type_t kind;
		logic [7:0] pos;
		roll = $urandom_range(99);
		bad = 1'b0;
		kind = REQ_READ;
		case (mix)
		GROW: begin
			if (roll < 75) kind = REQ_INSERT;
			else if (roll < 86) kind = REQ_READ;
			else if (roll < 93) kind = REQ_REMOVE;
			else bad = 1'b1;
		end
		SHRINK: begin
			if (roll < 60) kind = REQ_REMOVE;
			else if (roll < 80) kind = REQ_READ;
			else if (roll < 90) kind = REQ_INSERT;
			else bad = 1'b1;
		end
		default: begin
			if (roll < 30) kind = REQ_INSERT;
			else if (roll < 58) kind = REQ_READ;
			else if (roll < 83) kind = REQ_REMOVE;
			else if (roll < 87) kind = REQ_CLEAR;
			else bad = 1'b1;
		end
		endcase
		if (bad)
			kind = req_type_t'($urandom_range(2));
		case (kind)
		REQ_INSERT: begin
			if (bad)
				pos = 8'($urandom_range(255, shadow_len + 1));
			else
				pos = 8'($urandom_range(shadow_len, 0));
		end
		REQ_CLEAR: pos = 8'($urandom);
		default: begin
			if (bad)
				pos = 8'($urandom_range(255, shadow_len));
			else if (shadow_len == 0)
				pos = 8'd0;
			else
				pos = 8'($urandom_range(shadow_len - 1, 0));
		end
		endcase
		send_item(kind, pos, pick_value(), 1'b0, '0);
	endtask

	// response side: random stalls, plus one long hold-off on request
	initial begin
		rsp_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				hold_left--;
				rsp_ch.ready <= 1'b0;
			end else if (holds_done != hold_requests) begin
				holds_done++;
				hold_left = HOLD_CYCLES - 1;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= calm || ($urandom_range(99) >= 9);
			end
		end
	end

	always @(posedge clk) begin
		if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
			if (owed_results.size() == 0) begin
				report_mismatch("result with none owed", {30'd0, rsp_ch.status}, '0);
			end else begin
				head = owed_results.pop_front();
				if (rsp_ch.status !== head.st)
					report_mismatch("status", {30'd0, rsp_ch.status}, {30'd0, head.st});
				if (rsp_ch.read_value !== head.rd)
					report_mismatch("read_value", rsp_ch.read_value, head.rd);
				if (rsp_ch.count !== head.cnt)
					report_mismatch("count", {24'd0, rsp_ch.count}, {24'd0, head.cnt});
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (req_ch.valid === 1'b1 && req_ch.ready === 1'b1)
				|| (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("indexed_insert_delete_array: mismatch");
			$finish;
		end
	end

	initial begin
		int n;
		req_ch.valid <= 1'b0;
		req_ch.req_type <= REQ_READ;
		req_ch.position <= 8'd0;
		req_ch.new_value <= 32'sd0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (n = 0; n < NDIR; n++)
			send_item(directed_rows[n].kind, directed_rows[n].pos, directed_rows[n].val,
				directed_rows[n].typed_in, directed_rows[n].want);

		// fill to capacity, then push on the full array
		while (shadow_len < CAPACITY)
			send_random(GROW);
		repeat (10) send_random(GROW);
		repeat (60) send_random(SHRINK);

		// long response hold-off while requests keep coming
		hold_requests <= hold_requests + 1;
		repeat (40) send_random(CHURN);

		calm <= 1'b1;
		repeat (80) send_random(CHURN);
		calm <= 1'b0;

		while (shadow_len > 0)
			send_random(SHRINK);
		repeat (5) send_random(SHRINK);
		repeat (60) send_random(CHURN);
		req_ch.valid <= 1'b0;

		while (owed_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("indexed_insert_delete_array: match");
		else
			$display("indexed_insert_delete_array: mismatch");
		$finish;
	end
endmodule

[indexed_insert_delete_array.f]
hdl/iida_pkg.sv
hdl/iida_req_if.sv
hdl/iida_rsp_if.sv
hdl/iida_cell.sv
hdl/iida_read_tree.sv
hdl/indexed_insert_delete_array.sv
dv/tb.sv
